### rtl/core/mfss_pkg.sv
// Package for the MPEG-1 audio frame sync scanner: the result record, the
// header codes and the frame length tables. It depends on nothing.
package mfss_pkg;

  // Layer numbers as reported (layer code 3 is Layer I).
  localparam logic [1:0] LAYER_NONE = 2'd0;
  localparam logic [1:0] LAYER_I    = 2'd1;
  localparam logic [1:0] LAYER_II   = 2'd2;
  localparam logic [1:0] LAYER_III  = 2'd3;

  // Sampling rate codes.
  localparam logic [1:0] RATE_44K1     = 2'd0;
  localparam logic [1:0] RATE_48K      = 2'd1;
  localparam logic [1:0] RATE_32K      = 2'd2;
  localparam logic [1:0] RATE_RESERVED = 2'd3;

  localparam logic [3:0] BITRATE_FREE = 4'd0;
  localparam logic [3:0] BITRATE_BAD  = 4'd15;
  localparam logic [1:0] EMPH_BAD     = 2'd2;
  localparam logic [1:0] LCODE_BAD    = 2'd0;

  localparam int unsigned LEN_W = 11;

  // Slot counts per bitrate index, truncated, without padding.
  // Layer I: 12 * bitrate / fs; Layers II and III: 144 * bitrate / fs.
  localparam logic [10:0] L1_44K1 [16] = '{
    11'd0, 11'd8, 11'd17, 11'd26, 11'd34, 11'd43, 11'd52, 11'd60,
    11'd69, 11'd78, 11'd87, 11'd95, 11'd104, 11'd113, 11'd121, 11'd0};
  localparam logic [10:0] L1_48K [16] = '{
    11'd0, 11'd8, 11'd16, 11'd24, 11'd32, 11'd40, 11'd48, 11'd56,
    11'd64, 11'd72, 11'd80, 11'd88, 11'd96, 11'd104, 11'd112, 11'd0};
  localparam logic [10:0] L1_32K [16] = '{
    11'd0, 11'd12, 11'd24, 11'd36, 11'd48, 11'd60, 11'd72, 11'd84,
    11'd96, 11'd108, 11'd120, 11'd132, 11'd144, 11'd156, 11'd168, 11'd0};

  localparam logic [10:0] L2_44K1 [16] = '{
    11'd0, 11'd104, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313, 11'd365,
    11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044, 11'd1253, 11'd0};
  localparam logic [10:0] L2_48K [16] = '{
    11'd0, 11'd96, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288, 11'd336,
    11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960, 11'd1152, 11'd0};
  localparam logic [10:0] L2_32K [16] = '{
    11'd0, 11'd144, 11'd216, 11'd252, 11'd288, 11'd360, 11'd432, 11'd504,
    11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1440, 11'd1728, 11'd0};

  localparam logic [10:0] L3_44K1 [16] = '{
    11'd0, 11'd104, 11'd130, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313,
    11'd365, 11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044, 11'd0};
  localparam logic [10:0] L3_48K [16] = '{
    11'd0, 11'd96, 11'd120, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288,
    11'd336, 11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960, 11'd0};
  localparam logic [10:0] L3_32K [16] = '{
    11'd0, 11'd144, 11'd180, 11'd216, 11'd252, 11'd288, 11'd360, 11'd432,
    11'd504, 11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1440, 11'd0};

  typedef struct packed {
    logic              frame_found;
    logic [1:0]        layer_number;
    logic              crc_protected;
    logic [3:0]        bitrate_index;
    logic [1:0]        sample_rate_index;
    logic              padding_slot;
    logic [1:0]        channel_mode;
    logic [1:0]        mode_extension;
    logic              copyrighted;
    logic              original_media;
    logic [1:0]        emphasis_code;
    logic [LEN_W-1:0]  frame_bytes;
  } result_t;

  // Frame length in bytes; zero for free format.
  function automatic logic [LEN_W-1:0] frame_len(input logic [1:0] layer,
                                                 input logic [3:0] br,
                                                 input logic [1:0] sr,
                                                 input logic       pad);
    logic [10:0] slots;
    logic [8:0]  l1_slots;
    logic [LEN_W-1:0] len;
    slots = '0;
    case (layer)
      LAYER_I: begin
        case (sr)
          RATE_44K1: slots = L1_44K1[br];
          RATE_48K:  slots = L1_48K[br];
          RATE_32K:  slots = L1_32K[br];
          default:   slots = '0;
        endcase
      end
      LAYER_II: begin
        case (sr)
          RATE_44K1: slots = L2_44K1[br];
          RATE_48K:  slots = L2_48K[br];
          RATE_32K:  slots = L2_32K[br];
          default:   slots = '0;
        endcase
      end
      LAYER_III: begin
        case (sr)
          RATE_44K1: slots = L3_44K1[br];
          RATE_48K:  slots = L3_48K[br];
          RATE_32K:  slots = L3_32K[br];
          default:   slots = '0;
        endcase
      end
      default: slots = '0;
    endcase
    // Layer I slots are four bytes long.
    l1_slots = slots[8:0] + {8'd0, pad};
    if (br == BITRATE_FREE) begin
      len = '0;
    end else if (layer == LAYER_I) begin
      len = {l1_slots, 2'b00};
    end else begin
      len = slots + {10'd0, pad};
    end
    return len;
  endfunction

endpackage

### rtl/core/mfss_header_decode.sv
// Header check and field decode for a four-byte window of the scanner.
// Depends on mfss_pkg for the result record and the frame length tables.
module mfss_header_decode (
  input  logic [31:0]       header,
  output mfss_pkg::result_t result
);
  import mfss_pkg::*;

  logic [7:0] b0, b1, b2, b3;
  logic [1:0] lcode;
  logic [1:0] layer;
  logic       valid_hdr;

  assign b0 = header[31:24];
  assign b1 = header[23:16];
  assign b2 = header[15:8];
  assign b3 = header[7:0];

  assign lcode = b1[2:1];
  // Layer code 3, 2, 1 maps to Layer I, II, III.
  assign layer = 2'(3'd4 - {1'b0, lcode});

  assign valid_hdr = (b0 == 8'hFF) && (b1[7:4] == 4'hF) && b1[3] &&
                     (lcode != LCODE_BAD) && (b2[7:4] != BITRATE_BAD) &&
                     (b2[3:2] != RATE_RESERVED) && (b3[1:0] != EMPH_BAD);

  always_comb begin
    result = '0;
    if (valid_hdr) begin
      result.frame_found       = 1'b1;
      result.layer_number      = layer;
      result.crc_protected     = ~b1[0];
      result.bitrate_index     = b2[7:4];
      result.sample_rate_index = b2[3:2];
      result.padding_slot      = b2[1];
      result.channel_mode      = b3[7:6];
      result.mode_extension    = b3[5:4];
      result.copyrighted       = b3[3];
      result.original_media    = b3[2];
      result.emphasis_code     = b3[1:0];
      result.frame_bytes       = frame_len(layer, b2[7:4], b2[3:2], b2[1]);
    end
  end

endmodule

### rtl/core/mpeg_audio_frame_sync_scanner_unit.sv
// Top level of the MPEG-1 audio frame sync scanner.
// Depends on mfss_pkg and mfss_header_decode.
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ------------------------------------
//  input     data_valid / data_stall   data_byte, start_of_stream
//  result    result_valid /            frame_found, layer_number, ...,
//            result_stall              frame_bytes (one result per byte)
//
// Each byte request is taken when data_stall is low, and its result appears in the
// result register on the following cycle; one byte per cycle is sustained while
// no held result is stalled. The rate is set by the loop through the window,
// the header decode, the frame length table and the skip counter.
// Reset (rst, synchronous) clears the window, fill count, skip count and
// the result valid flag. While a held result is stalled, data_stall is
// raised so that no new request overwrites it.
module mpeg_audio_frame_sync_scanner_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        data_valid,
  output logic                        data_stall,
  input  logic [7:0]                  data_byte,
  input  logic                        start_of_stream,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic                        frame_found,
  output logic [1:0]                  layer_number,
  output logic                        crc_protected,
  output logic [3:0]                  bitrate_index,
  output logic [1:0]                  sample_rate_index,
  output logic                        padding_slot,
  output logic [1:0]                  channel_mode,
  output logic [1:0]                  mode_extension,
  output logic                        copyrighted,
  output logic                        original_media,
  output logic [1:0]                  emphasis_code,
  output logic [mfss_pkg::LEN_W-1:0]  frame_bytes
);
  import mfss_pkg::*;

  // Scanner state: the last three bytes, how many are valid, and the number
  // of window positions still to skip inside the current frame.
  logic [23:0]      byte_window, byte_window_next;
  logic [1:0]       fill_count, fill_count_next;
  logic [LEN_W-1:0] skip_count, skip_count_next;

  logic             accept;
  logic [23:0]      cur_window;
  logic [1:0]       cur_fill;
  logic [LEN_W-1:0] cur_skip;
  logic             check;
  result_t          decoded;
  result_t          result_next;
  result_t          result;

  assign data_stall = result_valid & result_stall;
  assign accept     = data_valid & ~data_stall;

  // A start of stream clears the state before this byte is taken.
  assign cur_window = start_of_stream ? '0 : byte_window;
  assign cur_fill   = start_of_stream ? '0 : fill_count;
  assign cur_skip   = start_of_stream ? '0 : skip_count;

  mfss_header_decode u_decode (
    .header ({cur_window, data_byte}),
    .result (decoded)
  );

  // A header is only looked for once the window is full and no frame body
  // is being skipped.
  assign check = (cur_fill == 2'd3) && (cur_skip == '0);

  always_comb begin
    byte_window_next = {cur_window[15:0], data_byte};
    fill_count_next  = (cur_fill == 2'd3) ? cur_fill : cur_fill + 2'd1;
    skip_count_next  = cur_skip;
    result_next      = '0;
    if (cur_fill == 2'd3) begin
      if (cur_skip != '0) begin
        skip_count_next = cur_skip - LEN_W'(1);
      end else if (decoded.frame_found) begin
        result_next = decoded;
        // Free format has no known length, so nothing is skipped.
        skip_count_next = (decoded.frame_bytes != '0) ?
                          decoded.frame_bytes - LEN_W'(1) : '0;
      end
    end
    if (!check) begin
      result_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_window  <= '0;
      fill_count   <= '0;
      skip_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        byte_window  <= byte_window_next;
        fill_count   <= fill_count_next;
        skip_count   <= skip_count_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign frame_found       = result.frame_found;
  assign layer_number      = result.layer_number;
  assign crc_protected     = result.crc_protected;
  assign bitrate_index     = result.bitrate_index;
  assign sample_rate_index = result.sample_rate_index;
  assign padding_slot      = result.padding_slot;
  assign channel_mode      = result.channel_mode;
  assign mode_extension    = result.mode_extension;
  assign copyrighted       = result.copyrighted;
  assign original_media    = result.original_media;
  assign emphasis_code     = result.emphasis_code;
  assign frame_bytes       = result.frame_bytes;

endmodule
